// ===== src/efhp_pkg.sv =====
package efhp_pkg;

	localparam int DEFAULT_MAX_FRAME_BYTES = 1518;
	localparam int INDEX_LIMIT             = 2047;
	localparam int CMP_W                   = 12;

	localparam logic [15:0] TYPE_LLC_MAX = 16'd1500;
	localparam logic [15:0] TYPE_IPV4    = 16'h0800;
	localparam logic [15:0] TYPE_ARP     = 16'h0806;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	typedef enum logic [1:0] {
		KIND_LLC   = 2'd0,
		KIND_IPV4  = 2'd1,
		KIND_ARP   = 2'd2,
		KIND_OTHER = 2'd3
	} frame_kind_t;

	typedef enum logic [1:0] {
		LLC_INFO  = 2'd0,
		LLC_SUPER = 2'd1,
		LLC_UNNUM = 2'd2,
		LLC_NONE  = 2'd3
	} llc_format_t;

	// LLC control byte low bits
	localparam logic [1:0] CTRL_S = 2'b01;
	localparam logic [1:0] CTRL_U = 2'b11;

	// frame state captured on the last beat
	typedef struct packed {
		logic [15:0] type_word;
		logic [15:0] llc_control;
		logic [5:0]  header_len;
		logic [7:0]  protocol;
		logic [20:0] sum_acc;
		logic [31:0] port_pair;
		logic [7:0]  flags;
		logic [15:0] aux_word;
		logic        tcp_offset_seen;
	} snapshot_t;

	typedef struct packed {
		frame_kind_t frame_kind;
		logic [15:0] type_length;
		llc_format_t llc_format;
		logic [6:0]  llc_code;
		logic [6:0]  llc_recv_seq;
		logic [7:0]  ip_protocol;
		logic [5:0]  ip_header_bytes;
		logic        ip_checksum_ok;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [7:0]  tcp_flags;
		logic [15:0] transport_word;
	} result_t;

	// fold the 21-bit sum twice into 16 bits and check for all ones
	function automatic logic checksum_good(input logic [20:0] sum);
		logic [16:0] f1;
		logic [16:0] f2;
		f1 = {1'b0, sum[15:0]} + {12'd0, sum[20:16]};
		f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
		return f2 == 17'h0ffff;
	endfunction

endpackage

// ===== src/efhp_frame_state.sv =====
module efhp_frame_state #(
	parameter int MAX_FRAME_BYTES = efhp_pkg::DEFAULT_MAX_FRAME_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          frame_byte,
	input  logic                last_byte,
	output efhp_pkg::snapshot_t snap
);
	import efhp_pkg::*;

	localparam int IDX_CAP = (MAX_FRAME_BYTES > INDEX_LIMIT) ? INDEX_LIMIT : MAX_FRAME_BYTES;
	localparam int IDX_W   = $clog2(IDX_CAP + 1);

	localparam logic [CMP_W-1:0] IDX_TYPE_HI = CMP_W'(12);
	localparam logic [CMP_W-1:0] IDX_TYPE_LO = CMP_W'(13);
	localparam logic [CMP_W-1:0] IDX_L3      = CMP_W'(14);
	localparam logic [CMP_W-1:0] IDX_CTRL1   = CMP_W'(16);
	localparam logic [CMP_W-1:0] IDX_CTRL2   = CMP_W'(17);
	localparam logic [CMP_W-1:0] IDX_ARP_HI  = CMP_W'(20);
	localparam logic [CMP_W-1:0] IDX_ARP_LO  = CMP_W'(21);
	localparam logic [CMP_W-1:0] IDX_PROTO   = CMP_W'(23);
	localparam logic [CMP_W-1:0] REL_AUX_HI  = CMP_W'(4);
	localparam logic [CMP_W-1:0] REL_AUX_LO  = CMP_W'(5);
	localparam logic [CMP_W-1:0] REL_TCP_OFF = CMP_W'(12);
	localparam logic [CMP_W-1:0] REL_TCP_FLG = CMP_W'(13);

	logic [IDX_W-1:0] byte_index_q, byte_index_d;
	logic [15:0]      type_word_q, type_word_d;
	logic [15:0]      llc_control_q, llc_control_d;
	logic [5:0]       header_len_q, header_len_d;
	logic [7:0]       protocol_q, protocol_d;
	logic [20:0]      sum_acc_q, sum_acc_d;
	logic [31:0]      port_pair_q, port_pair_d;
	logic [7:0]       flags_q, flags_d;
	logic [15:0]      aux_word_q, aux_word_d;

	logic [CMP_W-1:0] idx;
	logic [CMP_W-1:0] start;
	logic [CMP_W-1:0] rel;

	always_comb begin
		byte_index_d  = byte_index_q;
		type_word_d   = type_word_q;
		llc_control_d = llc_control_q;
		header_len_d  = header_len_q;
		protocol_d    = protocol_q;
		sum_acc_d     = sum_acc_q;
		port_pair_d   = port_pair_q;
		flags_d       = flags_q;
		aux_word_d    = aux_word_q;
		idx           = CMP_W'(byte_index_q);
		start         = IDX_L3 + CMP_W'(header_len_q);
		rel           = '0;

		if (byte_index_q < IDX_W'(IDX_CAP)) begin
			byte_index_d = byte_index_q + IDX_W'(1);
			if (idx == IDX_TYPE_HI) begin
				type_word_d = {frame_byte, 8'd0};
			end else if (idx == IDX_TYPE_LO) begin
				type_word_d = {type_word_q[15:8], frame_byte};
			end else if (idx >= IDX_L3) begin
				if (type_word_q <= TYPE_LLC_MAX) begin
					if (idx == IDX_CTRL1) begin
						llc_control_d[15:8] = frame_byte;
					end else if (idx == IDX_CTRL2) begin
						llc_control_d[7:0] = frame_byte;
					end
				end else if (type_word_q == TYPE_ARP) begin
					if (idx == IDX_ARP_HI) begin
						aux_word_d[15:8] = frame_byte;
					end else if (idx == IDX_ARP_LO) begin
						aux_word_d[7:0] = frame_byte;
					end
				end else if (type_word_q == TYPE_IPV4) begin
					if (idx == IDX_L3) begin
						header_len_d = {frame_byte[3:0], 2'b00};
					end
					if (idx == IDX_PROTO) begin
						protocol_d = frame_byte;
					end
					start = IDX_L3 + CMP_W'(header_len_d);
					// header words start on an even byte, so bit 0 picks the half
					if (idx < start) begin
						if (!idx[0]) begin
							sum_acc_d = sum_acc_q + {5'd0, frame_byte, 8'd0};
						end else begin
							sum_acc_d = sum_acc_q + {13'd0, frame_byte};
						end
					end else begin
						rel = idx - start;
						if (rel < REL_AUX_HI) begin
							unique case (rel[1:0])
								2'd0: port_pair_d[31:24] = frame_byte;
								2'd1: port_pair_d[23:16] = frame_byte;
								2'd2: port_pair_d[15:8]  = frame_byte;
								default: port_pair_d[7:0] = frame_byte;
							endcase
						end else if (rel == REL_AUX_HI) begin
							aux_word_d[15:8] = frame_byte;
						end else if (rel == REL_AUX_LO) begin
							aux_word_d[7:0] = frame_byte;
						end else if (rel == REL_TCP_OFF) begin
							if (protocol_d == PROTO_TCP) begin
								aux_word_d = {10'd0, frame_byte[7:4], 2'b00};
							end
						end else if (rel == REL_TCP_FLG) begin
							flags_d = frame_byte;
						end
					end
				end
			end
		end

		snap.type_word       = type_word_d;
		snap.llc_control     = llc_control_d;
		snap.header_len      = header_len_d;
		snap.protocol        = protocol_d;
		snap.sum_acc         = sum_acc_d;
		snap.port_pair       = port_pair_d;
		snap.flags           = flags_d;
		snap.aux_word        = aux_word_d;
		snap.tcp_offset_seen = CMP_W'(byte_index_d) > (IDX_L3 + CMP_W'(header_len_d) + REL_TCP_OFF);
	end

	// clear everything after the last beat of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= '0;
			type_word_q   <= '0;
			llc_control_q <= '0;
			header_len_q  <= '0;
			protocol_q    <= '0;
			sum_acc_q     <= '0;
			port_pair_q   <= '0;
			flags_q       <= '0;
			aux_word_q    <= '0;
		end else if (advance) begin
			if (last_byte) begin
				byte_index_q  <= '0;
				type_word_q   <= '0;
				llc_control_q <= '0;
				header_len_q  <= '0;
				protocol_q    <= '0;
				sum_acc_q     <= '0;
				port_pair_q   <= '0;
				flags_q       <= '0;
				aux_word_q    <= '0;
			end else begin
				byte_index_q  <= byte_index_d;
				type_word_q   <= type_word_d;
				llc_control_q <= llc_control_d;
				header_len_q  <= header_len_d;
				protocol_q    <= protocol_d;
				sum_acc_q     <= sum_acc_d;
				port_pair_q   <= port_pair_d;
				flags_q       <= flags_d;
				aux_word_q    <= aux_word_d;
			end
		end
	end

endmodule

// ===== src/efhp_summary.sv =====
module efhp_summary (
	input  efhp_pkg::snapshot_t snap,
	output efhp_pkg::result_t   res
);
	import efhp_pkg::*;

	logic [7:0] c1;
	logic [7:0] c2;

	always_comb begin
		c1 = snap.llc_control[15:8];
		c2 = snap.llc_control[7:0];
		res = '0;
		res.type_length = snap.type_word;
		res.llc_format  = LLC_NONE;

		if (snap.type_word <= TYPE_LLC_MAX) begin
			res.frame_kind = KIND_LLC;
			unique case (c1[1:0])
				CTRL_S: begin
					res.llc_format   = LLC_SUPER;
					res.llc_code     = {5'd0, c1[3:2]};
					res.llc_recv_seq = c2[7:1];
				end
				CTRL_U: begin
					res.llc_format = LLC_UNNUM;
					res.llc_code   = {2'd0, c1[7:5], c1[3:2]};
				end
				default: begin
					res.llc_format   = LLC_INFO;
					res.llc_code     = c1[7:1];
					res.llc_recv_seq = c2[7:1];
				end
			endcase
		end else if (snap.type_word == TYPE_IPV4) begin
			res.frame_kind      = KIND_IPV4;
			res.ip_protocol     = snap.protocol;
			res.ip_header_bytes = snap.header_len;
			res.ip_checksum_ok  = (snap.header_len != 6'd0) && checksum_good(snap.sum_acc);
			if (snap.protocol == PROTO_TCP) begin
				res.source_port    = snap.port_pair[31:16];
				res.dest_port      = snap.port_pair[15:0];
				res.tcp_flags      = snap.flags;
				res.transport_word = snap.tcp_offset_seen ? snap.aux_word : 16'd0;
			end else if (snap.protocol == PROTO_UDP) begin
				res.source_port    = snap.port_pair[31:16];
				res.dest_port      = snap.port_pair[15:0];
				res.transport_word = snap.aux_word;
			end else if (snap.protocol == PROTO_ICMP) begin
				res.transport_word = snap.port_pair[31:16];
			end
		end else if (snap.type_word == TYPE_ARP) begin
			res.frame_kind     = KIND_ARP;
			res.transport_word = snap.aux_word;
		end else begin
			res.frame_kind = KIND_OTHER;
		end
	end

endmodule

// ===== src/ethernet_frame_header_parser.sv =====
// Path: a last beat accepted on s_axis passes the input register, the snapshot register and
// the output register in turn before m_axis_tvalid presents its summary.
// Throughput: one byte per cycle; s_axis_tready drops only when a last byte in the input
// register finds the snapshot stage and the output register both full and m_axis_tready low.
// Stages: input register, frame state update / snapshot, summary decode to output register.
// Reset: arst_n asynchronous, active low; clears valid flags and all frame state.
module ethernet_frame_header_parser #(
	parameter int MAX_FRAME_BYTES = efhp_pkg::DEFAULT_MAX_FRAME_BYTES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] frame_byte
	input  logic         s_axis_tlast,   // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [15:0] type_length, [17:16] llc_format, [24:18] llc_code, [31:25] llc_recv_seq,
	// [39:32] ip_protocol, [45:40] ip_header_bytes, [46] ip_checksum_ok,
	// [62:47] source_port, [78:63] dest_port, [86:79] tcp_flags,
	// [102:87] transport_word, [103] zero
	output logic [103:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser    // [1:0] frame_kind
);
	import efhp_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// snapshot of a finished frame
	logic      valid_s2;
	snapshot_t snap_s2;
	snapshot_t snap_next;

	// output register
	logic    out_valid_q;
	result_t out_q;
	result_t res;

	logic out_free;
	logic s2_adv;
	logic s1_go;
	logic s1_take;

	// output register takes a new summary when empty or being drained
	assign out_free = !out_valid_q || m_axis_tready;
	assign s2_adv   = valid_s2 && out_free;
	// a plain byte always moves; a last byte needs room in the snapshot stage
	assign s1_go    = valid_s1 && (!last_s1 || !valid_s2 || out_free);
	assign s1_take  = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !valid_s1 || s1_go;

	efhp_frame_state #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (s1_go),
		.frame_byte(byte_s1),
		.last_byte (last_s1),
		.snap      (snap_next)
	);

	efhp_summary u_summary (
		.snap(snap_s2),
		.res (res)
	);

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (s1_go && last_s1) begin
				valid_s2 <= 1'b1;
			end else if (s2_adv) begin
				valid_s2 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// payload: hold while the stage downstream is stalled
	always_ff @(posedge clk) begin
		if (s1_take) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (s1_go && last_s1) begin
			snap_s2 <= snap_next;
		end
		if (s2_adv) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.frame_kind;
	assign m_axis_tdata  = {1'b0, out_q.transport_word, out_q.tcp_flags, out_q.dest_port,
		out_q.source_port, out_q.ip_checksum_ok, out_q.ip_header_bytes, out_q.ip_protocol,
		out_q.llc_recv_seq, out_q.llc_code, out_q.llc_format, out_q.type_length};

	// an empty input register never back-pressures
	assert property (@(posedge clk) disable iff (!arst_n) !valid_s1 |-> s_axis_tready)
		else $error("input stalled with empty input register");

	// a processed last byte lands in the snapshot stage
	assert property (@(posedge clk) disable iff (!arst_n) (s1_go && last_s1) |=> valid_s2)
		else $error("finished frame lost before snapshot");

	// a waiting snapshot is not dropped
	assert property (@(posedge clk) disable iff (!arst_n) (valid_s2 && !out_free) |=> valid_s2)
		else $error("snapshot dropped while output stalled");

	// a snapshot moved out shows up on the output
	assert property (@(posedge clk) disable iff (!arst_n) s2_adv |=> m_axis_tvalid)
		else $error("summary not presented after snapshot advance");

endmodule
